// File: src/hbsa_pkg.sv
// ----------------------------------------------------------------------------
// hbsa_pkg
// Shared constants, codes and types of the hierarchical bitmap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hbsa_pkg;

    // geometry, as log2 of each level
    localparam int SEG_W             = 5;
    localparam int WORD_W            = 5;
    localparam int BIT_W             = 6;
    localparam int SEGMENTS          = 1 << SEG_W;
    localparam int WORDS_PER_SEGMENT = 1 << WORD_W;
    localparam int BITS_PER_WORD     = 1 << BIT_W;
    localparam int ADDR_W            = SEG_W + WORD_W;
    localparam int TOTAL_WORDS       = 1 << ADDR_W;
    localparam int SLOT_W            = SEG_W + WORD_W + BIT_W;

    // shared zero-search unit, wide enough for any level
    localparam int FIND_W       = 64;
    localparam int FIND_IDX_W   = 6;
    localparam int FIND_START_W = 7;

    // stream fields
    localparam int FUNC_W      = 2;
    localparam int SLOT_IN_W   = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // function codes
    typedef logic [FUNC_W-1:0] func_t;
    localparam func_t FUNC_MARK = 2'd0;
    localparam func_t FUNC_FREE = 2'd1;
    localparam func_t FUNC_FIND = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_FW0,
        ST_FS1,
        ST_FS2,
        ST_FW1,
        ST_FRD,
        ST_FBIT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: src/hbsa_ram.sv
// ----------------------------------------------------------------------------
// hbsa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/hbsa_zfind.sv
// ----------------------------------------------------------------------------
// hbsa_zfind
// Shared search unit: lowest clear bit at or above a start position.
// ----------------------------------------------------------------------------
`default_nettype none

module hbsa_zfind
    import hbsa_pkg::*;
(
    input  wire logic [FIND_W-1:0]       vec,
    input  wire logic [FIND_START_W-1:0] start,
    output logic                         found,
    output logic      [FIND_IDX_W-1:0]   idx
);

    logic [FIND_W-1:0] masked;

    // bits below the start count as used
    always_comb
    begin
        for (int i = 0; i < FIND_W; i++)
        begin
            masked[i] = vec[i] | (FIND_START_W'(i) < start);
        end
    end

    // priority encoder on the lowest clear bit
    always_comb
    begin
        idx = '0;
        for (int i = FIND_W - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                idx = FIND_IDX_W'(i);
            end
        end
        found = ~&masked;
    end

endmodule

`default_nettype wire

// File: src/hierarchical_bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_slot_allocator
// Three-level occupancy bitmap over 65536 slots: mark, free and find-free.
// ----------------------------------------------------------------------------
// After reset the block clears the leaf word RAM, all 1024 words, and
// holds s_tready low meanwhile. It then takes one word at a time: a mark or
// free is a read-modify-write of one leaf word; a find makes as many passes
// of the shared zero-search unit as it needs, in this order (start word
// in its own segment, segment search above it, segment search from zero,
// lowest free word, then lowest free bit of the leaf word read from RAM).
// A find starts at bit 0 of the word holding the given slot and does not
// mark what it returns; status 1 means every slot is in use. A new word is
// accepted while the previous result still waits in the output register.
`default_nettype none

module hierarchical_bitmap_slot_allocator
    import hbsa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // func[1:0], slot[17:2]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata   // found_slot[15:0], status[16]
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]            clr_cnt_reg;
    func_t                        func_reg;
    logic [SEG_W-1:0]             seg_reg;
    logic [WORD_W-1:0]            wrd_reg;
    logic [BIT_W-1:0]             bit_reg;
    logic [SLOT_IN_W-1:0]         res_slot_reg;
    logic                         res_status_reg;
    logic                         m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]       m_tdata_reg;

    logic [WORDS_PER_SEGMENT-1:0] wfm_reg [SEGMENTS];
    logic [SEGMENTS-1:0]          segfull_reg;
    logic [WORDS_PER_SEGMENT-1:0] wfm_row_next;
    logic [SEGMENTS-1:0]          segfull_next;
    logic                         summary_we;

    logic                         accept;
    logic                         out_free;
    logic                         load_out;
    func_t                        in_func;
    logic [SLOT_IN_W+SLOT_W-1:0]  in_slot_ext;
    logic [SLOT_W+SLOT_IN_W-1:0]  found_ext;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_addr;
    logic [BITS_PER_WORD-1:0]     ram_wdata;
    logic [BITS_PER_WORD-1:0]     ram_rdata;
    logic [BITS_PER_WORD-1:0]     bit_mask;
    logic [BITS_PER_WORD-1:0]     new_word;
    logic [WORDS_PER_SEGMENT-1:0] wfm_cur;
    logic [WORDS_PER_SEGMENT-1:0] wrd_mask;

    logic [FIND_W-1:0]            zf_vec;
    logic [FIND_START_W-1:0]      zf_start;
    logic                         zf_found;
    logic [FIND_IDX_W-1:0]        zf_idx;

    // input field split
    assign in_func     = s_tdata[FUNC_W-1:0];
    assign in_slot_ext = {{SLOT_W{1'b0}}, s_tdata[FUNC_W+SLOT_IN_W-1:FUNC_W]};
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;

    // leaf word store
    hbsa_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (TOTAL_WORDS)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // shared zero-search unit
    hbsa_zfind u_zfind (
        .vec   (zf_vec),
        .start (zf_start),
        .found (zf_found),
        .idx   (zf_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(TOTAL_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_func)
                        FUNC_MARK: state_next = ST_RD;
                        FUNC_FREE: state_next = ST_RD;
                        FUNC_FIND: state_next = ST_FW0;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_RD:   state_next = ST_MOD;
            ST_MOD:  state_next = ST_OUT;
            ST_FW0:  state_next = zf_found ? ST_FRD : ST_FS1;
            ST_FS1:  state_next = zf_found ? ST_FW1 : ST_FS2;
            ST_FS2:  state_next = zf_found ? ST_FW1 : ST_OUT;
            ST_FW1:  state_next = ST_FRD;
            ST_FRD:  state_next = ST_FBIT;
            ST_FBIT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = {seg_reg, wrd_reg};
        ram_wdata = new_word;
        zf_vec    = {FIND_W{1'b1}};
        zf_start  = '0;
        load_out  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE: s_tready = 1'b1;
            ST_MOD:  ram_we   = 1'b1;
            ST_FW0:
            begin
                if (!segfull_reg[seg_reg])
                begin
                    zf_vec[WORDS_PER_SEGMENT-1:0] = wfm_cur;
                end
                zf_start = FIND_START_W'(wrd_reg);
            end
            ST_FS1:
            begin
                zf_vec[SEGMENTS-1:0] = segfull_reg;
                zf_start             = FIND_START_W'(seg_reg) + FIND_START_W'(1);
            end
            ST_FS2:  zf_vec[SEGMENTS-1:0] = segfull_reg;
            ST_FW1:  zf_vec[WORDS_PER_SEGMENT-1:0] = wfm_cur;
            ST_FBIT: zf_vec[BITS_PER_WORD-1:0] = ram_rdata;
            ST_OUT:  load_out = out_free;
            default: ;
        endcase
    end

    // leaf word update for mark and free
    assign wfm_cur  = wfm_reg[seg_reg];
    assign bit_mask = BITS_PER_WORD'(1) << bit_reg;
    assign wrd_mask = WORDS_PER_SEGMENT'(1) << wrd_reg;
    assign new_word = (func_reg == FUNC_MARK) ? (ram_rdata | bit_mask)
                                              : (ram_rdata & ~bit_mask);

    // full-mark update
    always_comb
    begin
        wfm_row_next = wfm_cur;
        segfull_next = segfull_reg;
        summary_we   = 1'b0;
        if (state_reg == ST_MOD)
        begin
            summary_we = 1'b1;
            if (func_reg == FUNC_MARK)
            begin
                if (&new_word)
                begin
                    wfm_row_next = wfm_cur | wrd_mask;
                    if (&wfm_row_next)
                    begin
                        segfull_next[seg_reg] = 1'b1;
                    end
                end
            end
            else
            begin
                wfm_row_next          = wfm_cur & ~wrd_mask;
                segfull_next[seg_reg] = 1'b0;
            end
        end
    end

    // control registers and summary masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            segfull_reg  <= '0;
            for (int s = 0; s < SEGMENTS; s++)
            begin
                wfm_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (summary_we)
            begin
                wfm_reg[seg_reg] <= wfm_row_next;
                segfull_reg      <= segfull_next;
            end
        end
    end

    // found slot composed from segment, word and bit
    assign found_ext = {{SLOT_IN_W{1'b0}}, seg_reg, wrd_reg, zf_idx[BIT_W-1:0]};

    // working word and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= in_func;
            bit_reg        <= in_slot_ext[BIT_W-1:0];
            wrd_reg        <= in_slot_ext[BIT_W+WORD_W-1:BIT_W];
            seg_reg        <= in_slot_ext[SLOT_W-1:BIT_W+WORD_W];
            res_slot_reg   <= '0;
            res_status_reg <= 1'b0;
        end
        case (state_reg)
            ST_FW0:
            begin
                if (zf_found)
                begin
                    wrd_reg <= zf_idx[WORD_W-1:0];
                end
            end
            ST_FS1:
            begin
                if (zf_found)
                begin
                    seg_reg <= zf_idx[SEG_W-1:0];
                end
            end
            ST_FS2:
            begin
                if (zf_found)
                begin
                    seg_reg <= zf_idx[SEG_W-1:0];
                end
                else
                begin
                    res_status_reg <= 1'b1;
                end
            end
            ST_FW1:  wrd_reg      <= zf_idx[WORD_W-1:0];
            ST_FBIT: res_slot_reg <= found_ext[SLOT_IN_W-1:0];
            default: ;
        endcase
        if (load_out)
        begin
            m_tdata_reg <= {{(OUT_TDATA_W - SLOT_IN_W - 1){1'b0}}, res_status_reg,
                            res_slot_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
